/* src/nlq_pkg.sv */
// ----------------------------------------------------------------------------
// Neighbor link-quality table package
// Shared state type, outcome codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package nlq_pkg;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

  localparam logic [1:0] OUTCOME_ADDED   = 2'd0;
  localparam logic [1:0] OUTCOME_UPDATED = 2'd1;
  localparam logic [1:0] OUTCOME_DROPPED = 2'd2;

  typedef struct packed {
    logic load;
    logic read;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic hit;
    logic miss;
    logic out_free;
  } dp_status_t;

endpackage

/* src/nlq_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nlq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/nlq_ctrl.sv */
// ----------------------------------------------------------------------------
// Neighbor table controller
// Sequences capture, table scan and commit of one transaction at a time.
// ----------------------------------------------------------------------------
module nlq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  nlq_pkg::dp_status_t status,
  output nlq_pkg::ctl_cmd_t   cmd
);

  nlq_pkg::state_t state;
  nlq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nlq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      nlq_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = nlq_pkg::ST_SCAN;
        end
      end
      nlq_pkg::ST_SCAN: begin
        // A decision waits here until the output register can take it.
        if (status.hit || status.miss) begin
          if (status.out_free) begin
            cmd.commit = 1'b1;
            state_next = nlq_pkg::ST_IDLE;
          end
        end else begin
          cmd.read = 1'b1;
        end
      end
      default: begin
        state_next = nlq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/nlq_dp.sv */
// ----------------------------------------------------------------------------
// Neighbor table datapath
// Holds the captured packet, entry count, scan pointer, table RAM and result.
// ----------------------------------------------------------------------------
module nlq_dp #(
  parameter int TABLE_DEPTH = 16,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  nlq_pkg::ctl_cmd_t   cmd,
  output nlq_pkg::dp_status_t status,
  input  logic [15:0]         sender_address,
  input  logic [15:0]         signal_strength,
  input  logic [15:0]         link_quality,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          outcome,
  output logic [3:0]          slot_used,
  output logic [4:0]          neighbor_count
);

  logic [15:0]   item_addr;
  logic [15:0]   item_rssi;
  logic [15:0]   item_lqi;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] idx;
  logic [IW-1:0] pidx;
  logic          rd_pend;
  logic [47:0]   rd_data;
  logic          hit;
  logic          full;
  logic          wr_en;
  logic [IW-1:0] slot_sel;
  logic [1:0]    outcome_next;
  logic [31:0]   slot_wide;
  logic [31:0]   count_wide;

  // Entries are only appended, so slots 0..count-1 are exactly the valid ones.
  assign hit  = rd_pend && (rd_data[47:32] == item_addr);
  assign full = (count == CW'(TABLE_DEPTH));

  assign status.hit      = hit;
  assign status.miss     = !hit && (idx == count);
  assign status.out_free = !out_valid || !out_stall;

  always_comb begin
    count_next = count;
    wr_en      = 1'b0;
    slot_sel   = '0;
    if (hit) begin
      slot_sel     = pidx;
      outcome_next = nlq_pkg::OUTCOME_UPDATED;
      wr_en        = cmd.commit;
    end else if (!full) begin
      slot_sel     = count[IW-1:0];
      outcome_next = nlq_pkg::OUTCOME_ADDED;
      wr_en        = cmd.commit;
      count_next   = count + CW'(1);
    end else begin
      outcome_next = nlq_pkg::OUTCOME_DROPPED;
    end
  end

  assign slot_wide  = 32'(slot_sel);
  assign count_wide = 32'(count_next);

  nlq_ram #(
    .WIDTH (48),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_sel),
    .wr_data ({item_addr, item_rssi, item_lqi}),
    .rd_en   (cmd.read),
    .rd_addr (idx[IW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_addr <= sender_address;
      item_rssi <= signal_strength;
      item_lqi  <= link_quality;
    end
    if (cmd.read) begin
      pidx <= idx[IW-1:0];
    end
    if (cmd.commit) begin
      outcome        <= outcome_next;
      slot_used      <= slot_wide[3:0];
      neighbor_count <= count_wide[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx     <= '0;
        rd_pend <= 1'b0;
      end else if (cmd.read) begin
        idx     <= idx + CW'(1);
        rd_pend <= 1'b1;
      end else if (cmd.commit) begin
        rd_pend <= 1'b0;
      end
      if (cmd.commit) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    idx <= count)
    else $error("scan pointer ran past the filled entries");

  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed transaction did not reach the output register");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && !hit && !full |=> count == $past(count) + CW'(1))
    else $error("new neighbor did not advance the entry count");

endmodule

/* src/neighbor_link_quality_table.sv */
// Each transaction is captured, the filled entries are scanned for its sender address (stopping
// on a hit), and the decision is committed to the output register. One transaction is handled at
// a time; the scan reads one entry per cycle through the single read port of the table RAM.
// The output register lets a new transaction start while a result still waits.
// Reset (rst, synchronous) empties the table by clearing the entry count; no clearing pass.
// ----------------------------------------------------------------------------
// Neighbor link-quality table
// Looks up a sender address, updates or appends its entry and reports the outcome.
// ----------------------------------------------------------------------------
module neighbor_link_quality_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] sender_address,
  input  logic [15:0] signal_strength,
  input  logic [15:0] link_quality,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  outcome,
  output logic [3:0]  slot_used,
  output logic [4:0]  neighbor_count
);

  nlq_pkg::ctl_cmd_t   cmd;
  nlq_pkg::dp_status_t status;

  nlq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  nlq_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .sender_address  (sender_address),
    .signal_strength (signal_strength),
    .link_quality    (link_quality),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .outcome         (outcome),
    .slot_used       (slot_used),
    .neighbor_count  (neighbor_count)
  );

endmodule
